### hw/rtl/wpt_pkg.sv
// Package: widths, register indexes and mode tables for the windowed periodic trigger.
package wpt_pkg;

  localparam int unsigned SECONDS_PER_CYCLE = 5;
  localparam int unsigned MODE_COUNT        = 19;

  localparam int unsigned CNT_W  = 32;  // cycle_count
  localparam int unsigned EPO_W  = 32;  // epoch registers
  localparam int unsigned ZONE_W = 17;  // zone offset
  localparam int unsigned MODE_W = 5;   // repeat mode
  localparam int unsigned CFG_W  = 32;  // config write data
  localparam int unsigned CYC_W  = 34;  // signed window bounds in cycles
  localparam int unsigned DIV_W  = 33;  // divider dividend
  localparam int unsigned DCNT_W = $clog2(DIV_W + 1);

  // reciprocal multiply for the epoch to cycle conversion
  localparam int unsigned MAC_N     = 3;
  localparam int unsigned CHK_W     = DIV_W / MAC_N;
  localparam int unsigned MAC_W     = $clog2(MAC_N + 1);
  localparam int unsigned RCP_W     = DIV_W + 1;
  localparam int unsigned PRD_W     = DIV_W + RCP_W;
  localparam int unsigned SPC_SHIFT = DIV_W + $clog2(SECONDS_PER_CYCLE);
  localparam logic [RCP_W-1:0] SPC_RECIP = RCP_W'(
    ((64'd1 << SPC_SHIFT) + 64'(SECONDS_PER_CYCLE) - 64'd1) / 64'(SECONDS_PER_CYCLE));

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_WIN_START   = 3'd1,
    REG_WIN_END     = 3'd2,
    REG_ZONE_OFFSET = 3'd3,
    REG_REPEAT_MODE = 3'd4
  } reg_idx_e;

  localparam logic [MODE_W-1:0] MODE_REALTIME = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_W'(4);

  localparam int unsigned PERIOD_SEC [MODE_COUNT] = '{
    0, 10, 20, 30, 60, 120, 300, 900, 1800, 3600, 7200,
    10800, 14400, 21600, 43200, 86400, 172800, 604800, 1209600
  };

  localparam int unsigned LATE_SEC [MODE_COUNT] = '{
    0, 15, 25, 40, 75, 150, 375, 1125, 2250, 4500, 8100,
    11700, 15300, 22500, 44100, 90000, 176400, 608400, 1213200
  };

  localparam int unsigned DVS_W = $clog2(LATE_SEC[MODE_COUNT-1] / SECONDS_PER_CYCLE + 1);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [DVS_W-1:0] period_cycles(input logic [MODE_W-1:0] m);
    int unsigned d;
    d = 1;
    if (int'(m) < MODE_COUNT) begin
      d = PERIOD_SEC[m] / SECONDS_PER_CYCLE;
    end
    if (d == 0) begin
      d = 1;
    end
    return DVS_W'(d);
  endfunction

  function automatic logic [DVS_W-1:0] late_cycles(input logic [MODE_W-1:0] m);
    int unsigned d;
    d = 1;
    if (int'(m) < MODE_COUNT) begin
      d = LATE_SEC[m] / SECONDS_PER_CYCLE;
    end
    if (d == 0) begin
      d = 1;
    end
    return DVS_W'(d);
  endfunction

endpackage

### hw/rtl/wpt_ifs.sv
// Interfaces: check item channel and result item channel.
interface wpt_in_if;
  import wpt_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] cycle_count;
  modport source (output valid, output cycle_count, input ready);
  modport sink   (input valid, input cycle_count, output ready);
endinterface

interface wpt_out_if;
  logic valid;
  logic ready;
  logic fire;
  modport source (output valid, output fire, input ready);
  modport sink   (input valid, input fire, output ready);
endinterface

### hw/rtl/wpt_div.sv
// Shared restoring divider, one quotient bit per cycle.
module wpt_div
  import wpt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVS_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DIV_W);
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

### hw/rtl/windowed_periodic_trigger.sv
// Top level: windowed periodic trigger with a shared iterative divider.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      cycle_count[31:0]
//  out_ch    out  valid/ready      fire
//  cfg       in   cfg_we_i         cfg_idx_i[2:0], cfg_data_i[31:0]
//
// One item at a time; in_ch.ready is high only while idle.
// From input accept to result valid: outside the window, in realtime mode or with an
// unused mode the check goes straight to the result; else a period check runs one
// 33-step pass of the shared divider, and a nonzero remainder adds a late check pass.
// The first item after a write to the window or offset registers first converts the
// bounds: two reciprocal multiplications of 3 steps each, in states S_LO and S_HI.
// A result waits in the output register while out_ch stalls.
// Reset is asynchronous, active low; no clearing pass.
module windowed_periodic_trigger
  import wpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  wpt_in_if.sink           in_ch,
  wpt_out_if.source        out_ch,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LO   = 7'b0000010,
    S_HI   = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_PER  = 7'b0010000,
    S_LATE = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic              enable_q;
  logic [EPO_W-1:0]  start_q;
  logic [EPO_W-1:0]  end_q;
  logic [ZONE_W-1:0] zone_q;
  logic [MODE_W-1:0] mode_q;
  logic              dirty_q, dirty_d;

  logic signed [CYC_W-1:0] lo_q, lo_d;
  logic signed [CYC_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DIV_W-1:0]  elapsed_q, elapsed_d;
  logic              neg_q, neg_d;
  logic              flag_q, flag_d;
  logic              fire_q, fire_d;
  logic              out_valid_q, out_valid_d;
  logic              res_q, res_d;
  logic [DIV_W-1:0]  mq_q, mq_d;
  logic [PRD_W-1:0]  acc_q, acc_d;
  logic [MAC_W-1:0]  step_q, step_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [CYC_W-1:0] zone_ext;
  logic signed [CYC_W-1:0] sum_lo, sum_hi;
  logic signed [CYC_W-1:0] count_s;
  logic signed [CYC_W-1:0] diff;
  logic signed [CYC_W-1:0] quo_s;
  logic [CHK_W+RCP_W-1:0]  mac_prod;
  logic [PRD_W-1:0]        mac_sum;
  logic [DIV_W-1:0]        cyc_mag;
  logic                    in_window;
  logic                    load_out;

  assign zone_ext = CYC_W'($signed(zone_q));
  assign sum_lo   = $signed({2'b00, start_q}) + zone_ext;
  assign sum_hi   = $signed({2'b00, end_q}) + zone_ext;
  assign count_s  = $signed({2'b00, count_q});
  assign diff     = count_s - lo_q;
  // magnitude * SPC_RECIP, one CHK_W-bit slice per step, top slice first
  assign mac_prod = {{RCP_W{1'b0}}, mq_q[DIV_W-1 -: CHK_W]} * {{CHK_W{1'b0}}, SPC_RECIP};
  assign mac_sum  = {acc_q[PRD_W-CHK_W-1:0], {CHK_W{1'b0}}} + PRD_W'(mac_prod);
  assign cyc_mag  = DIV_W'(acc_q >> SPC_SHIFT);
  assign quo_s    = neg_q ? -$signed({1'b0, cyc_mag})
                          :  $signed({1'b0, cyc_mag});
  assign in_window = enable_q && (count_s > lo_q) && (count_s < hi_q);
  assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

  function automatic logic [DIV_W-1:0] magnitude(input logic signed [CYC_W-1:0] v);
    logic [CYC_W-1:0] a;
    a = v[CYC_W-1] ? CYC_W'(-v) : CYC_W'(v);
    return a[DIV_W-1:0];
  endfunction

  wpt_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    dirty_d   = dirty_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    count_d   = count_q;
    elapsed_d = elapsed_q;
    neg_d     = neg_q;
    flag_d    = flag_q;
    res_d     = res_q;
    mq_d      = mq_q;
    acc_d     = acc_q;
    step_d    = step_q;
    div_req   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_ch.valid) begin
          count_d = in_ch.cycle_count;
          if (dirty_q) begin
            mq_d    = magnitude(sum_lo);
            acc_d   = '0;
            step_d  = '0;
            neg_d   = sum_lo[CYC_W-1];
            state_d = S_LO;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_LO: begin
        if (step_q == MAC_W'(MAC_N)) begin
          lo_d    = quo_s;
          mq_d    = magnitude(sum_hi);
          acc_d   = '0;
          step_d  = '0;
          neg_d   = sum_hi[CYC_W-1];
          state_d = S_HI;
        end else begin
          mq_d   = {mq_q[DIV_W-CHK_W-1:0], {CHK_W{1'b0}}};
          acc_d  = mac_sum;
          step_d = step_q + MAC_W'(1);
        end
      end
      S_HI: begin
        if (step_q == MAC_W'(MAC_N)) begin
          hi_d    = quo_s;
          dirty_d = 1'b0;
          state_d = S_CHK;
        end else begin
          mq_d   = {mq_q[DIV_W-CHK_W-1:0], {CHK_W{1'b0}}};
          acc_d  = mac_sum;
          step_d = step_q + MAC_W'(1);
        end
      end
      S_CHK: begin
        elapsed_d = diff[DIV_W-1:0];
        if (in_window && (mode_q != MODE_REALTIME) && (int'(mode_q) < MODE_COUNT)) begin
          div_req.start    = 1'b1;
          div_req.dividend = diff[DIV_W-1:0];
          div_req.divisor  = period_cycles(mode_q);
          state_d          = S_PER;
        end else begin
          res_d   = in_window && (mode_q == MODE_REALTIME);
          state_d = S_DONE;
        end
      end
      S_PER: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            flag_d  = 1'b1;
            res_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = elapsed_q;
            div_req.divisor  = late_cycles(mode_q);
            state_d          = S_LATE;
          end
        end
      end
      S_LATE: begin
        if (div_rsp.done) begin
          res_d = 1'b0;
          if (div_rsp.remainder == '0) begin
            if (!flag_q) begin
              res_d = 1'b1;
            end else begin
              flag_d = 1'b0;
            end
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i && ((cfg_idx_i == REG_WIN_START) || (cfg_idx_i == REG_WIN_END) ||
                     (cfg_idx_i == REG_ZONE_OFFSET))) begin
      dirty_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    fire_d      = fire_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      fire_d      = res_q;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      start_q  <= '0;
      end_q    <= '0;
      zone_q   <= '0;
      mode_q   <= MODE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE:      enable_q <= cfg_data_i[0];
        REG_WIN_START:   start_q  <= cfg_data_i[EPO_W-1:0];
        REG_WIN_END:     end_q    <= cfg_data_i[EPO_W-1:0];
        REG_ZONE_OFFSET: zone_q   <= cfg_data_i[ZONE_W-1:0];
        REG_REPEAT_MODE: mode_q   <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dirty_q     <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q   <= count_d;
    elapsed_q <= elapsed_d;
    neg_q     <= neg_d;
    res_q     <= res_d;
    fire_q    <= fire_d;
    mq_q      <= mq_d;
    acc_q     <= acc_d;
    step_q    <= step_d;
  end

  assign in_ch.ready  = (state_q == S_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.fire  = fire_q;

endmodule

### hw/rtl/wpt_chk.sv
// Checker: port-level assertions for the windowed periodic trigger, with bind.
module wpt_chk (
  input logic             clk_i,
  input logic             rst_ni,
  wpt_in_if.sink          in_ch,
  wpt_out_if.source       out_ch
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.fire))
    else $error("result item dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ch.ready)
    else $error("ready high in the cycle after an accepted item");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> pend_q != 2'd0)
    else $error("result item with no item outstanding");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q != 2'd2)
    else $error("item accepted with two results outstanding");

endmodule

bind windowed_periodic_trigger wpt_chk u_wpt_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ch     (in_ch),
  .out_ch    (out_ch)
);
